// ===== rtl/bfe_pkg.sv =====
`timescale 1ns / 1ps

package bfe_pkg;

  localparam int ByteWidth      = 8;
  localparam int TypeWidth      = 2;
  localparam int StampWidth     = 48;
  localparam int IdxWidth       = 4;
  localparam int StampSelWidth  = 3;

  localparam logic [ByteWidth-1:0] EscByte         = 8'h1A;
  localparam logic [ByteWidth-1:0] TypeBase        = 8'h31;
  localparam logic [ByteWidth-1:0] MaxPayloadReset = 8'd14;

  localparam logic OpHeader  = 1'b0;
  localparam logic OpPayload = 1'b1;

  // byte positions inside an encoded header
  localparam logic [IdxWidth-1:0] IdxLead    = 4'd0;
  localparam logic [IdxWidth-1:0] IdxType    = 4'd1;
  localparam logic [IdxWidth-1:0] IdxTsLast  = 4'd7;
  localparam logic [IdxWidth-1:0] IdxSig     = 4'd8;

  localparam int QueueDepthDefault = 4;

  typedef struct packed {
    logic                  is_header;
    logic [TypeWidth-1:0]  frame_type;
    logic [StampWidth-1:0] timestamp;
    logic [ByteWidth-1:0]  signal_level;
    logic [ByteWidth-1:0]  data_byte;
    logic                  frame_end;
  } cmd_t;

endpackage

// ===== rtl/bfe_in_if.sv =====
`timescale 1ns / 1ps

interface bfe_in_if;
  logic                            valid;
  logic                            ready;
  logic                            op;
  logic [bfe_pkg::TypeWidth-1:0]   frame_type;
  logic [bfe_pkg::StampWidth-1:0]  timestamp;
  logic [bfe_pkg::ByteWidth-1:0]   signal_level;
  logic [bfe_pkg::ByteWidth-1:0]   payload_length;
  logic [bfe_pkg::ByteWidth-1:0]   data_byte;

  modport source (
    output valid, op, frame_type, timestamp, signal_level, payload_length, data_byte,
    input  ready
  );
  modport sink (
    input  valid, op, frame_type, timestamp, signal_level, payload_length, data_byte,
    output ready
  );
endinterface

// ===== rtl/bfe_out_if.sv =====
`timescale 1ns / 1ps

interface bfe_out_if;
  logic                          valid;
  logic                          ready;
  logic [bfe_pkg::ByteWidth-1:0] out_byte;
  logic                          run_last;
  logic                          frame_end;

  modport source (
    output valid, out_byte, run_last, frame_end,
    input  ready
  );
  modport sink (
    input  valid, out_byte, run_last, frame_end,
    output ready
  );
endinterface

// ===== rtl/bfe_front.sv =====
`timescale 1ns / 1ps

module bfe_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [bfe_pkg::ByteWidth-1:0] cfg_wr_data,
  bfe_in_if.sink                        frame_in,
  input  logic                          q_full,
  output logic                          push,
  output bfe_pkg::cmd_t                 push_cmd
);
  import bfe_pkg::*;

  logic [ByteWidth-1:0] max_payload_length;
  logic [ByteWidth-1:0] bytes_remaining;
  logic                 discarding;
  logic [ByteWidth-1:0] rem_dec;
  logic                 accept;
  logic                 too_long;

  assign frame_in.ready = !q_full;
  assign accept   = frame_in.valid && frame_in.ready;
  assign rem_dec  = bytes_remaining - 8'd1;
  assign too_long = frame_in.payload_length > max_payload_length;

  always_comb begin
    push                  = 1'b0;
    push_cmd.is_header    = (frame_in.op == OpHeader);
    push_cmd.frame_type   = frame_in.frame_type;
    push_cmd.timestamp    = frame_in.timestamp;
    push_cmd.signal_level = frame_in.signal_level;
    push_cmd.data_byte    = frame_in.data_byte;
    push_cmd.frame_end    = 1'b0;
    if (accept) begin
      if (frame_in.op == OpHeader) begin
        push               = !too_long;
        push_cmd.frame_end = (frame_in.payload_length == '0);
      end else if (bytes_remaining != '0 && !discarding) begin
        push               = 1'b1;
        push_cmd.frame_end = (rem_dec == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_length <= MaxPayloadReset;
      bytes_remaining    <= '0;
      discarding         <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_payload_length <= cfg_wr_data;
      end
      if (accept) begin
        if (frame_in.op == OpHeader) begin
          bytes_remaining <= frame_in.payload_length;
          discarding      <= too_long && (frame_in.payload_length != '0);
        end else if (bytes_remaining != '0) begin
          bytes_remaining <= rem_dec;
          if (rem_dec == '0) begin
            discarding <= 1'b0;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/bfe_queue.sv =====
`timescale 1ns / 1ps

module bfe_queue #(
  parameter int Depth = bfe_pkg::QueueDepthDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bfe_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output bfe_pkg::cmd_t head_cmd
);
  import bfe_pkg::*;

  localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(Depth - 1);
  localparam logic [CntWidth-1:0] CntFull = CntWidth'(Depth);

  cmd_t                mem [Depth];
  logic [PtrWidth-1:0] wr_ptr;
  logic [PtrWidth-1:0] rd_ptr;
  logic [CntWidth-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full      = (count == CntFull);
  assign not_empty = (count != '0);
  assign head_cmd  = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/bfe_back.sv =====
`timescale 1ns / 1ps

module bfe_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  bfe_pkg::cmd_t q_cmd,
  output logic          q_pop,
  bfe_out_if.source     byte_out
);
  import bfe_pkg::*;

  cmd_t                    cmd;
  logic                    active;
  logic [IdxWidth-1:0]     idx;
  logic                    dup;
  logic [ByteWidth-1:0]    cur_byte;
  logic [StampSelWidth-1:0] ts_sel;
  logic [StampWidth-1:0]   ts_shift;
  logic                    needs_esc;
  logic                    final_byte;
  logic                    step;

  assign ts_sel   = StampSelWidth'(IdxTsLast - idx);
  assign ts_shift = cmd.timestamp >> {ts_sel, 3'b000};

  always_comb begin
    if (!cmd.is_header) begin
      cur_byte = cmd.data_byte;
    end else begin
      case (idx)
        IdxLead: cur_byte = EscByte;
        IdxType: cur_byte = TypeBase + {6'b0, cmd.frame_type};
        IdxSig:  cur_byte = cmd.signal_level;
        default: cur_byte = ts_shift[ByteWidth-1:0];
      endcase
    end
  end

  assign needs_esc  = (cur_byte == EscByte) && !(cmd.is_header && idx == IdxLead) && !dup;
  assign final_byte = (!cmd.is_header || idx == IdxSig) && !needs_esc;
  assign step       = active && (!byte_out.valid || byte_out.ready);
  assign q_pop      = q_valid && (!active || (step && final_byte));

  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      idx            <= '0;
      dup            <= 1'b0;
      byte_out.valid <= 1'b0;
    end else begin
      if (step) begin
        byte_out.valid <= 1'b1;
      end else if (byte_out.ready) begin
        byte_out.valid <= 1'b0;
      end
      if (q_pop) begin
        active <= 1'b1;
        idx    <= '0;
        dup    <= 1'b0;
      end else if (step) begin
        if (needs_esc) begin
          dup <= 1'b1;
        end else begin
          dup <= 1'b0;
          if (final_byte) begin
            active <= 1'b0;
          end else begin
            idx <= idx + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_cmd;
    end
    if (step) begin
      byte_out.out_byte  <= cur_byte;
      byte_out.run_last  <= final_byte;
      byte_out.frame_end <= final_byte && cmd.frame_end;
    end
  end

endmodule

// ===== rtl/beast_frame_escape_encoder_unit.sv =====
`timescale 1ns / 1ps
// channel    | dir | handshake     | word
// frame_in   | in  | valid / ready | op, frame_type, timestamp, signal_level,
//            |     |               | payload_length, data_byte
// byte_out   | out | valid / ready | out_byte, run_last, frame_end
// cfg        | in  | cfg_wr_en     | cfg_wr_data = max_payload_length
//
// the back end sends one byte per cycle unless byte_out stalls, from a
// registered output: a header is 9 to 16 bytes, a payload word 1 or 2 (0x1a doubled)
// the front takes one word per cycle while the command queue has room;
// words that give no bytes are taken the same way
// rst is synchronous; it clears the queue, frame state and sets the limit to 14
// a stalled output holds the back end; the queue decouples the front until it fills

module beast_frame_escape_encoder_unit #(
  parameter int QueueDepth = bfe_pkg::QueueDepthDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [bfe_pkg::ByteWidth-1:0] cfg_wr_data,
  bfe_in_if.sink                        frame_in,
  bfe_out_if.source                     byte_out
);
  import bfe_pkg::*;

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic q_pop;
  logic q_valid;
  cmd_t q_cmd;

  bfe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .frame_in    (frame_in),
    .q_full      (q_full),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  bfe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_cmd  (q_cmd)
  );

  bfe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .byte_out (byte_out)
  );

endmodule
